// ===== sv/vbb_pkg.sv =====
// Shared types, constants and register codes for the voxel bounding box block.
`default_nettype none
package vbb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration registers
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VOXEL_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     VOXEL_SIZE_RST   = 31'd65536;

  // Axis codes
  localparam int AXIS_W = 2;
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_STEP = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } vbb_state_t;

  typedef struct packed {
    logic              load_point; // accumulate the accepted centre
    logic              div_load;   // set up the divider for cmd axis
    logic              div_step;   // one quotient bit
    logic              div_last;   // last quotient bit: write the count
    logic              mul;        // first partial product
    logic              fin;        // final product, outputs, clear accumulators
    logic [AXIS_W-1:0] axis;
  } vbb_cmd_t;

endpackage
`default_nettype wire

// ===== sv/vbb_ctrl.sv =====
// Sequencer: point accumulation, per-axis division passes and the final product.
`default_nettype none
module vbb_ctrl
  import vbb_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic last_point,
  output logic      busy,
  output vbb_cmd_t  cmd
);

  localparam int BIT_W = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(COUNT_WIDTH - 1);

  vbb_state_t        state_r, state_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        axis_nxt = AXIS_X;
        cmd.load_point = start;
        if (start && last_point) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        bit_nxt = '0;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.div_step = 1'b1;
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BIT_LAST) begin
          cmd.div_last = 1'b1;
          axis_nxt = axis_r + 1'b1;
          state_nxt = (axis_r == AXIS_Z) ? S_MUL : S_LOAD;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AXIS_X;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/vbb_datapath.sv =====
// Corner accumulators, shared bit-serial divider, count product and result registers.
`default_nettype none
module vbb_datapath
  import vbb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire vbb_cmd_t                      cmd,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  input  wire logic signed [COORD_WIDTH-1:0] center_x,
  input  wire logic signed [COORD_WIDTH-1:0] center_y,
  input  wire logic signed [COORD_WIDTH-1:0] center_z,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      box_min_x,
  output logic signed [COORD_WIDTH-1:0]      box_min_y,
  output logic signed [COORD_WIDTH-1:0]      box_min_z,
  output logic signed [COORD_WIDTH-1:0]      box_max_x,
  output logic signed [COORD_WIDTH-1:0]      box_max_y,
  output logic signed [COORD_WIDTH-1:0]      box_max_z,
  output logic [COUNT_WIDTH-1:0]             count_x,
  output logic [COUNT_WIDTH-1:0]             count_y,
  output logic [COUNT_WIDTH-1:0]             count_z,
  output logic [3*COUNT_WIDTH-1:0]           voxel_total
);

  // corner arithmetic wide enough for centre +/- half size without wrap
  localparam int EXT_W  = ((COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W) + 2;
  // grown extent: hi - lo + 2*size, never negative at a set end
  localparam int SPAN_W = ((COORD_WIDTH + 1 > CFG_W + 2) ? COORD_WIDTH + 1 : CFG_W + 2) + 1;
  localparam int HI_W   = SPAN_W - COUNT_WIDTH;
  localparam int CMP_W  = (HI_W > CFG_W) ? HI_W : CFG_W;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [CFG_W-1:0] width_r, height_r;

  logic signed [COORD_WIDTH-1:0] center [3];
  logic signed [COORD_WIDTH-1:0] lo_r [3];
  logic signed [COORD_WIDTH-1:0] hi_r [3];
  logic [COUNT_WIDTH-1:0]        cnt_r [3];

  logic signed [COORD_WIDTH-1:0] out_min_r [3];
  logic signed [COORD_WIDTH-1:0] out_max_r [3];
  logic [COUNT_WIDTH-1:0]        out_cnt_r [3];
  logic [3*COUNT_WIDTH-1:0]      total_r;
  logic [2*COUNT_WIDTH-1:0]      prod_r;
  logic                          out_valid_r;

  // divider state
  logic [CFG_W-1:0]       rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] num_r;
  logic [COUNT_WIDTH-1:0] quo_r, quo_nxt;
  logic                   sat_r, zero_r;

  assign center[0] = center_x;
  assign center[1] = center_y;
  assign center[2] = center_z;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= VOXEL_SIZE_RST;
      height_r <= VOXEL_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOXEL_WIDTH:  width_r  <= cfg_wdata;
        REG_VOXEL_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-axis corner accumulation
  for (genvar g = 0; g < 3; g++) begin : g_axis
    logic [CFG_W-1:0]        size_g;
    logic signed [EXT_W-1:0] c_e, half_e, lo_e, hi_e;
    logic signed [COORD_WIDTH-1:0] lo_c, hi_c;

    assign size_g = (g == 2) ? height_r : width_r;
    assign c_e    = EXT_W'(center[g]);
    assign half_e = $signed(EXT_W'({1'b0, size_g[CFG_W-1:1]}));
    assign lo_e   = c_e - half_e;
    assign hi_e   = c_e + half_e;

    always_comb begin
      if (lo_e < EXT_W'(COORD_MIN)) begin
        lo_c = COORD_MIN;
      end else begin
        lo_c = lo_e[COORD_WIDTH-1:0];
      end
      if (hi_e > EXT_W'(COORD_MAX)) begin
        hi_c = COORD_MAX;
      end else begin
        hi_c = hi_e[COORD_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n || cmd.fin) begin
        lo_r[g] <= COORD_MAX;
        hi_r[g] <= COORD_MIN;
      end else if (cmd.load_point) begin
        if (lo_c < lo_r[g]) lo_r[g] <= lo_c;
        if (hi_c > hi_r[g]) hi_r[g] <= hi_c;
      end
    end
  end

  // shared divider: grown extent / voxel size, one quotient bit a cycle
  logic [CFG_W-1:0]  size_sel;
  logic [SPAN_W-1:0] span;
  logic              span_pos;
  logic [CMP_W-1:0]  span_hi, size_cmp;
  logic [CFG_W:0]    trial, diff;
  logic              ge;

  always_comb begin
    unique case (cmd.axis)
      AXIS_Z:  size_sel = height_r;
      default: size_sel = width_r;
    endcase
  end

  assign span = SPAN_W'(hi_r[cmd.axis]) - SPAN_W'(lo_r[cmd.axis])
              + SPAN_W'({size_sel, 1'b0});
  assign span_pos = !span[SPAN_W-1] && (span != '0);
  assign span_hi  = CMP_W'(span[SPAN_W-1:COUNT_WIDTH]);
  assign size_cmp = CMP_W'(size_sel);

  assign trial   = {rem_r, num_r[COUNT_WIDTH-1]};
  assign ge      = (trial >= {1'b0, size_sel});
  assign diff    = trial - {1'b0, size_sel};
  assign rem_nxt = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  assign quo_nxt = {quo_r[COUNT_WIDTH-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      // quotient of COUNT_WIDTH bits overflows when the top part already reaches the size
      sat_r  <= (size_sel == '0) || (span_pos && (span_hi >= size_cmp));
      zero_r <= !span_pos;
      rem_r  <= span_hi[CFG_W-1:0];
      num_r  <= span[COUNT_WIDTH-1:0];
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[COUNT_WIDTH-2:0], 1'b0};
      quo_r <= quo_nxt;
    end
    if (cmd.div_last) begin
      if (sat_r) begin
        cnt_r[cmd.axis] <= COUNT_MAX;
      end else if (zero_r) begin
        cnt_r[cmd.axis] <= '0;
      end else begin
        cnt_r[cmd.axis] <= quo_nxt;
      end
    end
  end

  // product in the mul and fin steps, and result registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= cnt_r[0] * cnt_r[1];
    end
    if (cmd.fin) begin
      total_r <= prod_r * cnt_r[2];
      for (int a = 0; a < 3; a++) begin
        out_min_r[a] <= lo_r[a];
        out_max_r[a] <= hi_r[a];
        out_cnt_r[a] <= cnt_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
    end
  end

  assign out_valid   = out_valid_r;
  assign box_min_x   = out_min_r[0];
  assign box_min_y   = out_min_r[1];
  assign box_min_z   = out_min_r[2];
  assign box_max_x   = out_max_r[0];
  assign box_max_y   = out_max_r[1];
  assign box_max_z   = out_max_r[2];
  assign count_x     = out_cnt_r[0];
  assign count_y     = out_cnt_r[1];
  assign count_z     = out_cnt_r[2];
  assign voxel_total = total_r;

endmodule
`default_nettype wire

// ===== sv/voxel_bounding_box.sv =====
// Top level of the voxel bounding box block: sequencer and datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | start, busy          | in_center_x/y/z, in_last_point
//  out     | out_valid (strobe)   | out_box_min/max_x/y/z, out_count_x/y/z,
//          |                      | out_voxel_total
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
// A centre without the last mark is taken with start; busy stays low.
// A centre with the last mark holds busy high while the shared one-bit-per-cycle
// divider runs over the three axes in turn and the count product is formed.
// out_valid pulses for one cycle as busy falls; the next transaction may be taken then.
// Synchronous active-low reset clears the box and restores both voxel sizes to 1.0.
// The receiver cannot stall; results are held until the next set completes.
`default_nettype none
module voxel_bounding_box
  import vbb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_center_z,
  input  wire logic                          in_last_point,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_box_min_x,
  output logic signed [COORD_WIDTH-1:0]      out_box_min_y,
  output logic signed [COORD_WIDTH-1:0]      out_box_min_z,
  output logic signed [COORD_WIDTH-1:0]      out_box_max_x,
  output logic signed [COORD_WIDTH-1:0]      out_box_max_y,
  output logic signed [COORD_WIDTH-1:0]      out_box_max_z,
  output logic [COUNT_WIDTH-1:0]             out_count_x,
  output logic [COUNT_WIDTH-1:0]             out_count_y,
  output logic [COUNT_WIDTH-1:0]             out_count_z,
  output logic [3*COUNT_WIDTH-1:0]           out_voxel_total,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata
);

  vbb_cmd_t cmd;

  vbb_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_point (in_last_point),
    .busy       (busy),
    .cmd        (cmd)
  );

  vbb_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .center_x    (in_center_x),
    .center_y    (in_center_y),
    .center_z    (in_center_z),
    .out_valid   (out_valid),
    .box_min_x   (out_box_min_x),
    .box_min_y   (out_box_min_y),
    .box_min_z   (out_box_min_z),
    .box_max_x   (out_box_max_x),
    .box_max_y   (out_box_max_y),
    .box_max_z   (out_box_max_z),
    .count_x     (out_count_x),
    .count_y     (out_count_y),
    .count_z     (out_count_z),
    .voxel_total (out_voxel_total)
  );

endmodule
`default_nettype wire
